/* rtl/core/tcgr_pkg.sv */
// Shared constants, codes and types of the text console glyph renderer.
`default_nettype none

package tcgr_pkg;

    // Font geometry and character handling.
    localparam int MAX_GLYPH_HEIGHT = 32;
    localparam int GLYPH_COUNT      = 256;
    localparam int TAB_WIDTH        = 8;

    // Storage and field widths.
    localparam int FONT_DEPTH  = 8192;
    localparam int FONT_AW     = 13;
    localparam int OFFSET_W    = 34;
    localparam int COUNTER_W   = 12;
    localparam int SCANLINE_W  = 16;
    localparam int WIDTH_W     = 15;
    localparam int HEIGHT_W    = 6;
    localparam int PROD_W      = COUNTER_W + SCANLINE_W;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 4;

    // One glyph row is 8 pixels of 4 bytes, so a column is 32 bytes wide.
    localparam int GLYPH_ROW_SHIFT = 5;
    // Pixels per glyph row as a shift, used by the wrap test.
    localparam int PIXEL_SHIFT     = 3;

    // Reset values of the configuration registers.
    localparam logic [SCANLINE_W-1:0] RESET_SCANLINE = 16'd4096;
    localparam logic [WIDTH_W-1:0]    RESET_WIDTH    = 15'd1024;
    localparam logic [HEIGHT_W-1:0]   RESET_HEIGHT   = 6'd16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_SCANLINE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT   = 2'd2;

    // Character codes with a meaning of their own.
    localparam logic [7:0] CHAR_NUL       = 8'd0;
    localparam logic [7:0] CHAR_TAB       = 8'd9;
    localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [7:0] CHAR_SPACE     = 8'd32;
    localparam logic [7:0] CHAR_NUL_GLYPH = 8'h42;

    typedef enum logic [0:0] {
        CMD_PUT_CHAR   = 1'b0,
        CMD_FONT_WRITE = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [SCANLINE_W-1:0] scanline;
        logic [WIDTH_W-1:0]    width;
        logic [HEIGHT_W-1:0]   height;
    } cfg_t;

    // Work handed from the front to the back: a font write or a glyph to draw.
    typedef struct packed {
        logic                  font_write;
        logic [FONT_AW-1:0]    addr;
        logic [7:0]            data;
        logic [OFFSET_W-1:0]   offset;
        logic [HEIGHT_W-1:0]   height;
    } entry_t;

endpackage

`default_nettype wire

/* rtl/core/tcgr_queue.sv */
// Short queue of work entries between the front and the back.
`default_nettype none

module tcgr_queue
    import tcgr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push_valid,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output entry_t pop_entry,
    output logic   not_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t          slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            push;
    logic            pop_fire;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign push      = push_valid && !full;
    assign pop_fire  = pop && not_empty;
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_fire) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop_fire) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop_fire && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !not_empty))
        else $error("queue popped while empty");

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue count above depth");

    a_pointers_agree: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with differing pointers");

endmodule

`default_nettype wire

/* rtl/core/tcgr_front.sv */
// Front part: accepts items, keeps the cursor and prepares draw and font-write work.
`default_nettype none

module tcgr_front
    import tcgr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_command,
    input  logic [7:0]           s_character,
    input  logic [FONT_AW-1:0]   s_font_address,
    input  logic [7:0]           s_font_byte,
    output logic                 push_valid,
    output entry_t               push_entry,
    input  logic                 push_full
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t               state_reg, state_next;
    logic [COUNTER_W-1:0]  col_reg, col_next;
    logic [COUNTER_W-1:0]  row_reg, row_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [COUNTER_W-1:0]  col_snap_reg, col_snap_next;
    logic [7:0]            glyph_reg, glyph_next;
    entry_t                entry_reg, entry_next;

    logic                  accept;
    logic [HEIGHT_W-1:0]   height_eff;
    logic [COUNTER_W-1:0]  col_inc;
    logic                  wrap;
    logic [COUNTER_W-1:0]  adv_col;
    logic [COUNTER_W-1:0]  adv_row;
    logic [COUNTER_W-1:0]  tab_col;
    logic [7:0]            char_eff;
    logic [7:0]            glyph;

    assign s_ready    = (state_reg == F_IDLE);
    assign accept     = s_valid && s_ready;
    assign push_valid = (state_reg == F_PUSH);
    assign push_entry = entry_reg;

    assign height_eff = (cfg.height > HEIGHT_W'(MAX_GLYPH_HEIGHT))
                      ? HEIGHT_W'(MAX_GLYPH_HEIGHT) : cfg.height;

    // Column advance with wrap to the next row once the column passes the width.
    assign col_inc = col_reg + 1'b1;
    assign wrap    = ({col_inc, {PIXEL_SHIFT{1'b0}}} > cfg.width);
    assign adv_col = wrap ? '0 : col_inc;
    assign adv_row = wrap ? row_reg + 1'b1 : row_reg;

    assign tab_col = COUNTER_W'(((int'(col_reg) / TAB_WIDTH) + 1) * TAB_WIDTH);

    assign char_eff = (s_character == CHAR_NUL) ? CHAR_NUL_GLYPH : s_character;
    assign glyph    = (int'(char_eff) >= GLYPH_COUNT)
                    ? 8'(int'(char_eff) - GLYPH_COUNT) : char_eff;

    always_comb begin
        state_next    = state_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        prod_next     = prod_reg;
        col_snap_next = col_snap_reg;
        glyph_next    = glyph_reg;
        entry_next    = entry_reg;
        case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    if (cmd_t'(s_command) == CMD_FONT_WRITE) begin
                        entry_next.font_write = 1'b1;
                        entry_next.addr       = s_font_address;
                        entry_next.data       = s_font_byte;
                        entry_next.offset     = '0;
                        entry_next.height     = '0;
                        state_next            = F_PUSH;
                    end else if (s_character == CHAR_NEWLINE) begin
                        col_next = '0;
                        row_next = row_reg + 1'b1;
                    end else if (s_character == CHAR_TAB) begin
                        col_next = tab_col;
                    end else begin
                        col_next = adv_col;
                        row_next = adv_row;
                        if (s_character != CHAR_SPACE && height_eff != '0) begin
                            prod_next     = PROD_W'(row_reg) * PROD_W'(cfg.scanline);
                            col_snap_next = col_reg;
                            glyph_next    = glyph;
                            state_next    = F_MUL;
                        end
                    end
                end
            end
            F_MUL: begin
                entry_next.font_write = 1'b0;
                entry_next.addr       = FONT_AW'(glyph_reg) * FONT_AW'(height_eff);
                entry_next.data       = '0;
                entry_next.offset     = OFFSET_W'(prod_reg) * OFFSET_W'(height_eff)
                                      + (OFFSET_W'(col_snap_reg) << GLYPH_ROW_SHIFT);
                entry_next.height     = height_eff;
                state_next            = F_PUSH;
            end
            F_PUSH: begin
                if (!push_full) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg     <= prod_next;
        col_snap_reg <= col_snap_next;
        glyph_reg    <= glyph_next;
        entry_reg    <= entry_next;
    end

endmodule

`default_nettype wire

/* rtl/core/tcgr_back.sv */
// Back part: font store, glyph row sequencer and result output register.
`default_nettype none

module tcgr_back
    import tcgr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [SCANLINE_W-1:0]  scanline,
    input  logic                   q_valid,
    input  entry_t                 q_entry,
    output logic                   q_pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [OFFSET_W-1:0]    m_byte_offset,
    output logic [7:0]             m_row_bits,
    output logic                   m_last_row
);

    logic [7:0]            font_mem [FONT_DEPTH];

    logic                  draw_reg;
    logic [FONT_AW-1:0]    addr_reg;
    logic [OFFSET_W-1:0]   offs_reg;
    logic [HEIGHT_W-1:0]   line_reg;
    logic [HEIGHT_W-1:0]   height_reg;

    logic                  p1_valid_reg;
    logic [OFFSET_W-1:0]   p1_offs_reg;
    logic                  p1_last_reg;
    logic [7:0]            rd_data_reg;

    logic                  out_valid_reg;
    logic [OFFSET_W-1:0]   out_offs_reg;
    logic [7:0]            out_bits_reg;
    logic                  out_last_reg;

    logic                  adv_out;
    logic                  issue;
    logic                  is_last;

    assign adv_out = p1_valid_reg && (!out_valid_reg || m_ready);
    assign issue   = draw_reg && (!p1_valid_reg || adv_out);
    assign q_pop   = !draw_reg && q_valid;
    assign is_last = (HEIGHT_W'(line_reg + 1'b1) == height_reg);

    assign m_valid       = out_valid_reg;
    assign m_byte_offset = out_offs_reg;
    assign m_row_bits    = out_bits_reg;
    assign m_last_row    = out_last_reg;

    // Font store: written by font-write entries, read one glyph row per issue.
    always_ff @(posedge aclk) begin
        if (q_pop && q_entry.font_write) begin
            font_mem[q_entry.addr] <= q_entry.data;
        end
        if (issue) begin
            rd_data_reg <= font_mem[addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            draw_reg      <= 1'b0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop && !q_entry.font_write) begin
                draw_reg <= 1'b1;
            end else if (issue && is_last) begin
                draw_reg <= 1'b0;
            end
            if (issue) begin
                p1_valid_reg <= 1'b1;
            end else if (adv_out) begin
                p1_valid_reg <= 1'b0;
            end
            if (adv_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            addr_reg   <= q_entry.addr;
            offs_reg   <= q_entry.offset;
            line_reg   <= '0;
            height_reg <= q_entry.height;
        end else if (issue) begin
            addr_reg <= addr_reg + 1'b1;
            offs_reg <= offs_reg + OFFSET_W'(scanline);
            line_reg <= line_reg + 1'b1;
        end
        if (issue) begin
            p1_offs_reg <= offs_reg;
            p1_last_reg <= is_last;
        end
        if (adv_out) begin
            out_offs_reg <= p1_offs_reg;
            out_bits_reg <= rd_data_reg;
            out_last_reg <= p1_last_reg;
        end
    end

    a_line_below_height: assert property (@(posedge aclk) disable iff (!aresetn)
        draw_reg |-> (line_reg < height_reg))
        else $error("glyph row counter passed the glyph height");

    a_stalled_output_holds_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && out_valid_reg && !m_ready) |=> p1_valid_reg)
        else $error("read stage dropped a row while the output stalled");

endmodule

`default_nettype wire

/* rtl/core/text_console_glyph_renderer_top.sv */
// Top level of the text console glyph renderer: configuration registers and part wiring.
`default_nettype none

// The renderer keeps a text cursor and an 8192-byte font store and turns each
// put-character item into one result item per glyph row: the framebuffer byte
// offset of the row's leftmost pixel (the caller adds the framebuffer base) and
// the eight pixel bits, bit 7 leftmost, with last_row marking the final row.
// Newline, tab and space only move the cursor; font-write items load one font
// byte and give no result. The front part accepts the next item once back in
// idle: a font write passes through its push state, a drawn character through
// its multiply and push states (two registered multiplies form the row offset),
// and push waits while the queue is full. The back part draws one glyph row per
// cycle from the single read port of the font store while the output is not
// stalled and takes a new entry after a draw's last row; results pass the row
// registers, the font read register and the output register. A small queue lets
// the front keep accepting items while the back part is still drawing. The font
// store has no reset: a glyph row must be written before it is drawn.
// Configuration is to be written only while no item is in flight.

module text_console_glyph_renderer_top
    import tcgr_pkg::*;
#(
    parameter int QUEUE_ENTRIES = QUEUE_DEPTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wr_data,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_command,
    input  logic [7:0]              s_character,
    input  logic [FONT_AW-1:0]      s_font_address,
    input  logic [7:0]              s_font_byte,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [OFFSET_W-1:0]     m_byte_offset,
    output logic [7:0]              m_row_bits,
    output logic                    m_last_row
);

    cfg_t    cfg_reg;
    logic    push_valid;
    entry_t  push_entry;
    logic    push_full;
    logic    q_pop;
    entry_t  q_entry;
    logic    q_valid;

    // Configuration registers. Writes to an index beyond the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scanline <= RESET_SCANLINE;
            cfg_reg.width    <= RESET_WIDTH;
            cfg_reg.height   <= RESET_HEIGHT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SCANLINE: cfg_reg.scanline <= cfg_wr_data;
                CFG_WIDTH:    cfg_reg.width    <= cfg_wr_data[WIDTH_W-1:0];
                CFG_HEIGHT:   cfg_reg.height   <= cfg_wr_data[HEIGHT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The front part classifies each item, moves the cursor at once and queues
    // any font write or glyph to draw together with its precomputed offset.
    tcgr_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_character    (s_character),
        .s_font_address (s_font_address),
        .s_font_byte    (s_font_byte),
        .push_valid     (push_valid),
        .push_entry     (push_entry),
        .push_full      (push_full)
    );

    // Font writes travel through the same queue as draws, so every draw sees
    // exactly the font writes that were accepted before it.
    tcgr_queue #(
        .DEPTH (QUEUE_ENTRIES)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .full       (push_full),
        .pop        (q_pop),
        .pop_entry  (q_entry),
        .not_empty  (q_valid)
    );

    // The back part owns the font store and emits the glyph rows.
    tcgr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .scanline      (cfg_reg.scanline),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_byte_offset (m_byte_offset),
        .m_row_bits    (m_row_bits),
        .m_last_row    (m_last_row)
    );

endmodule

`default_nettype wire

/* bench/glyph_row_checker.sv */
// Checker that predicts the glyph rows of the console renderer and compares them with its output.
module glyph_row_checker
    import tcgr_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wr_data,

    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic                    s_command,
    input  logic [7:0]              s_character,
    input  logic [FONT_AW-1:0]      s_font_address,
    input  logic [7:0]              s_font_byte,

    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic [OFFSET_W-1:0]     m_byte_offset,
    input  logic [7:0]              m_row_bits,
    input  logic                    m_last_row,

    output int                      mismatch_count,
    output int                      rows_pending
);

    localparam int PIXELS_PER_ROW = 8;
    localparam int COLUMN_BYTES   = 32;
    // Mismatches beyond this many are still counted but no longer printed.
    localparam int PRINT_LIMIT    = 40;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [7:0]          bits;
        logic                last;
    } glyph_row_t;

    glyph_row_t            expected_rows[$];
    logic [SCANLINE_W-1:0] scanline;
    logic [WIDTH_W-1:0]    width_px;
    logic [HEIGHT_W-1:0]   height_cfg;
    logic [COUNTER_W-1:0]  cursor_column;
    logic [COUNTER_W-1:0]  cursor_row;
    logic [7:0]            font_mem [FONT_DEPTH];

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT)
            $display("checker: %s", what);
        mismatch_count++;
    endtask

    task automatic next_text_row();
        cursor_column = '0;
        cursor_row    = cursor_row + 1'b1;
    endtask

    // Move one cell right; wrap when the new column starts past the visible width.
    task automatic advance_cursor();
        cursor_column = cursor_column + 1'b1;
        if (int'(cursor_column) * PIXELS_PER_ROW > int'(width_px))
            next_text_row();
    endtask

    task automatic predict_glyph_rows(input cmd_t cmd, input logic [7:0] ch,
                                      input logic [FONT_AW-1:0] addr, input logic [7:0] data);
        int          glyph;
        int          rows;
        int          base;
        int          line;
        logic [63:0] offs;
        glyph_row_t  r;
        if (cmd == CMD_FONT_WRITE) begin
            font_mem[addr] = data;
        end else if (ch == CHAR_NEWLINE) begin
            next_text_row();
        end else if (ch == CHAR_TAB) begin
            // Tabs jump to the next stop without any wrap test.
            cursor_column = COUNTER_W'((int'(cursor_column) / TAB_WIDTH + 1) * TAB_WIDTH);
        end else begin
            if (ch != CHAR_SPACE) begin
                glyph = (ch == CHAR_NUL) ? int'(CHAR_NUL_GLYPH) : int'(ch);
                glyph = glyph % GLYPH_COUNT;
                rows  = (int'(height_cfg) > MAX_GLYPH_HEIGHT) ? MAX_GLYPH_HEIGHT
                                                              : int'(height_cfg);
                base  = glyph * rows;
                offs  = 64'(cursor_column) * COLUMN_BYTES
                      + 64'(cursor_row) * 64'(scanline) * 64'(rows);
                for (line = 0; line < rows; line++) begin
                    r.offset = offs[OFFSET_W-1:0];
                    r.bits   = font_mem[(base + line) % FONT_DEPTH];
                    r.last   = (line + 1 == rows);
                    expected_rows.push_back(r);
                    offs = offs + 64'(scanline);
                end
            end
            advance_cursor();
        end
    endtask

    // Inputs only move at the rising edge, so the falling edge sees exactly what
    // the next rising edge will act on.
    always @(negedge aclk) begin
        glyph_row_t want;
        if (!aresetn) begin
            scanline       = RESET_SCANLINE;
            width_px       = RESET_WIDTH;
            height_cfg     = RESET_HEIGHT;
            cursor_column  = '0;
            cursor_row     = '0;
            mismatch_count = 0;
            expected_rows.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SCANLINE: scanline   = cfg_wr_data;
                    CFG_WIDTH:    width_px   = cfg_wr_data[WIDTH_W-1:0];
                    CFG_HEIGHT:   height_cfg = cfg_wr_data[HEIGHT_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                predict_glyph_rows(cmd_t'(s_command), s_character, s_font_address, s_font_byte);
            if (m_valid && m_ready) begin
                if (expected_rows.size() == 0) begin
                    report_mismatch($sformatf("unexpected row at offset %0h", m_byte_offset));
                end else begin
                    want = expected_rows.pop_front();
                    if (m_byte_offset !== want.offset)
                        report_mismatch($sformatf("byte_offset %0h, expected %0h",
                                                  m_byte_offset, want.offset));
                    if (m_row_bits !== want.bits)
                        report_mismatch($sformatf("row_bits %02h, expected %02h at offset %0h",
                                                  m_row_bits, want.bits, want.offset));
                    if (m_last_row !== want.last)
                        report_mismatch($sformatf("last_row %0b, expected %0b at offset %0h",
                                                  m_last_row, want.last, want.offset));
                end
            end
        end
        rows_pending = expected_rows.size();
    end

endmodule

/* bench/testbench.sv */
// Top of the renderer testbench: clock, reset, stimulus phases, receiver and final verdict.
module testbench;
    import tcgr_pkg::*;

    localparam int HALF_PERIOD   = 4;
    // Far above the slowest correct run, even with full-height glyphs drained
    // against a receiver that stalls most cycles.
    localparam int CYCLE_LIMIT   = 1_000_000;
    // Waited out after the last owed row, so the back end can finish work that
    // owes no row, such as font writes still in the queue.
    localparam int QUIET_CYCLES  = 200;
    localparam int HOLD_CYCLES   = 400;
    localparam int ALPHABET_SIZE = 2;

    logic                   aclk           = 1'b0;
    logic                   aresetn        = 1'b0;
    logic                   cfg_wr_en      = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index      = CFG_SCANLINE;
    logic [CFG_DATA_W-1:0]  cfg_wr_data    = '0;
    logic                   s_valid        = 1'b0;
    logic                   s_ready;
    logic                   s_command      = CMD_PUT_CHAR;
    logic [7:0]             s_character    = '0;
    logic [FONT_AW-1:0]     s_font_address = '0;
    logic [7:0]             s_font_byte    = '0;
    logic                   m_valid;
    logic                   m_ready        = 1'b0;
    logic [OFFSET_W-1:0]    m_byte_offset;
    logic [7:0]             m_row_bits;
    logic                   m_last_row;

    int                     mismatch_count;
    int                     rows_pending;

    // Stimulus knobs; hold_seen, hold_left and cycle_count are kept by other processes.
    int                     idle_pct    = 0;
    int                     stall_pct   = 0;
    int                     cur_height  = int'(RESET_HEIGHT);
    int                     cycle_count = 0;
    // Toggling this asks the receiver process for one long hold-off.
    logic                   hold_toggle = 1'b0;
    logic                   hold_seen   = 1'b0;
    int                     hold_left   = 0;
    // Font entries written so far; a glyph is only drawn once all its rows are here.
    bit                     font_loaded [FONT_DEPTH];
    logic [7:0]             alphabet [ALPHABET_SIZE];

    text_console_glyph_renderer_top u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_character    (s_character),
        .s_font_address (s_font_address),
        .s_font_byte    (s_font_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_byte_offset  (m_byte_offset),
        .m_row_bits     (m_row_bits),
        .m_last_row     (m_last_row)
    );

    glyph_row_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_character    (s_character),
        .s_font_address (s_font_address),
        .s_font_byte    (s_font_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_byte_offset  (m_byte_offset),
        .m_row_bits     (m_row_bits),
        .m_last_row     (m_last_row),
        .mismatch_count (mismatch_count),
        .rows_pending   (rows_pending)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Watchdog: a hung handshake or a row that never arrives ends up here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver. It stalls at random with the current stall percentage, and when
    // the stimulus flips hold_toggle it holds ready low for a long stretch so the
    // renderer's queue fills and the input side backs up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready   <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Offers one item and returns right after the rising edge that accepts it.
    // Valid stays high across back-to-back items; it only drops for an idle gap.
    // Ready is looked at on the falling edge, where nothing is in motion.
    task automatic push_item(input cmd_t cmd, input logic [7:0] ch,
                             input logic [FONT_AW-1:0] addr, input logic [7:0] data);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < idle_pct)
                @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_command      <= cmd;
        s_character    <= ch;
        s_font_address <= addr;
        s_font_byte    <= data;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
    endtask

    // The font fields of a put-character item are don't-care, so they carry noise.
    task automatic put_char(input logic [7:0] ch);
        push_item(CMD_PUT_CHAR, ch, FONT_AW'($urandom_range(0, FONT_DEPTH - 1)),
                  8'($urandom_range(0, 255)));
    endtask

    // The character field of a font write is ignored by the block.
    task automatic write_font(input logic [FONT_AW-1:0] addr, input logic [7:0] data,
                              input logic [7:0] ch);
        push_item(CMD_FONT_WRITE, ch, addr, data);
        font_loaded[addr] = 1'b1;
    endtask

    // Loads any glyph row that was never written at the current height, then
    // prints the character. This keeps every font read on a written entry.
    task automatic draw_char(input logic [7:0] ch);
        int rows;
        int glyph;
        int line;
        int addr;
        rows  = (cur_height > MAX_GLYPH_HEIGHT) ? MAX_GLYPH_HEIGHT : cur_height;
        glyph = ((ch == CHAR_NUL) ? int'(CHAR_NUL_GLYPH) : int'(ch)) % GLYPH_COUNT;
        for (line = 0; line < rows; line++) begin
            addr = (glyph * rows + line) % FONT_DEPTH;
            if (!font_loaded[addr])
                write_font(FONT_AW'(addr), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
        end
        put_char(ch);
    endtask

    // Stops offering items and waits until every predicted row has come out,
    // then lets the back end finish any work that owes no row.
    task automatic settle();
        s_valid <= 1'b0;
        while (rows_pending != 0)
            @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    // Writes all three registers on consecutive edges. Only called while idle.
    task automatic set_config(input logic [SCANLINE_W-1:0] scan,
                              input logic [WIDTH_W-1:0] width_px,
                              input logic [HEIGHT_W-1:0] height);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_SCANLINE;
        cfg_wr_data <= scan;
        @(posedge aclk);
        cfg_index   <= CFG_WIDTH;
        cfg_wr_data <= CFG_DATA_W'(width_px);
        @(posedge aclk);
        cfg_index   <= CFG_HEIGHT;
        cfg_wr_data <= CFG_DATA_W'(height);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_height = int'(height);
    endtask

    // New phase: drain, reconfigure, set the idling mix and pick a fresh set of
    // characters so that different glyphs and font addresses get used.
    task automatic start_phase(input logic [SCANLINE_W-1:0] scan,
                               input logic [WIDTH_W-1:0] width_px,
                               input logic [HEIGHT_W-1:0] height,
                               input int send_idle, input int recv_stall);
        settle();
        set_config(scan, width_px, height);
        foreach (alphabet[i])
            alphabet[i] = 8'($urandom_range(0, 255));
        idle_pct  = send_idle;
        stall_pct <= recv_stall;
    endtask

    // Mostly drawn characters, with cursor controls and stray font writes mixed in.
    task automatic random_op();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            write_font(FONT_AW'($urandom_range(0, FONT_DEPTH - 1)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        else if (pick < 18)
            put_char(CHAR_NEWLINE);
        else if (pick < 26)
            put_char(CHAR_TAB);
        else if (pick < 36)
            put_char(CHAR_SPACE);
        else if (pick < 42)
            draw_char(CHAR_NUL);
        else
            draw_char(alphabet[$urandom_range(0, ALPHABET_SIZE - 1)]);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed items. A scanline near the widest and the narrowest screen make the
        // wrap come after two cells; a three-row font keeps the loading short.
        set_config(16'd65532, 15'd8, 6'd3);
        write_font(13'd8191, 8'hFF, 8'h00);
        write_font(13'd0, 8'h00, 8'hFF);
        draw_char(CHAR_NUL);                    // NUL comes out as the 'B' glyph
        draw_char(8'd255);
        draw_char(CHAR_NUL_GLYPH);              // a real 'B' reads the same rows
        put_char(CHAR_SPACE);
        draw_char(8'd1);
        put_char(CHAR_TAB);                     // tab past the visible width
        draw_char(8'h80);                       // drawn after the tab, then wraps
        put_char(CHAR_NEWLINE);
        write_font(13'h1555, 8'hA5, CHAR_NEWLINE);   // newline code in a font write
        draw_char(8'h41);

        // Reset scanline and width with short glyphs, everything flowing at full rate.
        start_phase(RESET_SCANLINE, RESET_WIDTH, 6'd4, 0, 0);
        repeat (14) random_op();

        // Smallest scanline and width with one-row glyphs; the sender mostly idles.
        start_phase(16'd4, 15'd8, 6'd1, 87, 0);
        repeat (14) random_op();

        // Height above the maximum, so every glyph is clamped to the tallest size,
        // against a receiver that stalls most cycles. It first holds off
        // completely while the sender keeps offering draws, so the queue fills.
        start_phase(16'd65532, 15'd16384, 6'd40, 0, 87);
        hold_toggle <= ~hold_toggle;
        repeat (6) draw_char(CHAR_NUL);
        put_char(CHAR_SPACE);
        put_char(CHAR_NEWLINE);
        repeat (2) draw_char(CHAR_NUL_GLYPH);

        // Random geometry with short glyphs and both sides idling; halfway through
        // the sender stops until every row owed so far has come out.
        start_phase(SCANLINE_W'($urandom_range(4, 65535)), WIDTH_W'($urandom_range(8, 32767)),
                    HEIGHT_W'($urandom_range(1, 8)), 31, 31);
        repeat (8) random_op();
        settle();
        repeat (8) random_op();

        // Zero glyph height: nothing is drawn but the cursor still moves.
        start_phase(16'd200, 15'd100, 6'd0, 0, 0);
        repeat (8) random_op();

        settle();
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
rtl/core/tcgr_pkg.sv
rtl/core/tcgr_queue.sv
rtl/core/tcgr_front.sv
rtl/core/tcgr_back.sv
rtl/core/text_console_glyph_renderer_top.sv
bench/glyph_row_checker.sv
bench/testbench.sv
